// File: src/mtm_pkg.sv
// ============================================================================
// MIDI trigger matcher package
// Shared types, codes and sizes for the trigger matcher block.
// ============================================================================
package mtm_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 32;
    localparam int PORT_COUNT  = 2;
    localparam int IDX_W       = 5;
    localparam int PORT_W      = 1;
    localparam int ADDR_W      = PORT_W + IDX_W;
    localparam int TABLE_WORDS = 2 ** ADDR_W;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // MIDI byte constants.
    localparam logic [3:0] CLS_NOTE_ON = 4'h9;
    localparam logic [3:0] CLS_CTRL    = 4'hB;
    localparam logic [3:0] CLS_PROG    = 4'hC;
    localparam logic [3:0] CLS_PRESS   = 4'hD;

    // Item kinds carried on the input channel.
    typedef enum logic [1:0] {
        MODE_BYTE   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_SET    = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    // Message kinds held in the trigger table.
    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_PROG     = 3'd1,
        KIND_CTRL     = 3'd2,
        KIND_NOTE_ON  = 3'd3,
        KIND_NOTE_OFF = 3'd4
    } kind_t;

    // Parser phase of one receive port.
    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_SCAN    = 2'd1,
        ST_RESOLVE = 2'd2
    } state_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       rx_port;
        logic [7:0] midi_byte;
        logic [4:0] entry_index;
        logic [2:0] entry_type;
        logic [3:0] entry_channel;
        logic [6:0] entry_first;
        logic [6:0] entry_second;
    } in_item_t;

    typedef struct packed {
        logic [4:0] preset_index;
        logic       match_port;
    } out_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] chan;
        logic [6:0] first;
        logic [6:0] second;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic scan;
        logic emit;
    } mtm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic msg_done;
        logic hit;
        logic scan_end;
        logic same_active;
        logic out_busy;
    } mtm_stat_t;

endpackage

// File: src/mtm_if.sv
// ============================================================================
// MIDI trigger matcher channels
// Valid/ready channels for input items and result items.
// ============================================================================
interface mtm_in_if import mtm_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mtm_out_if import mtm_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/mtm_ctrl.sv
// ============================================================================
// MIDI trigger matcher controller
// Sequences item intake, the table scan and the emission of a result.
// ============================================================================
module mtm_ctrl import mtm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  mtm_stat_t stat,
    output mtm_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && stat.msg_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.hit)
                begin
                    state_next = ST_RESOLVE;
                end
                else if (stat.scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESOLVE:
            begin
                if (stat.same_active || !stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_RESOLVE:
            begin
                cmd.emit = !stat.same_active && !stat.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/mtm_dp.sv
// ============================================================================
// MIDI trigger matcher datapath
// Byte parsers, trigger table memory, scan pipeline, active preset and
// result register.
// ============================================================================
module mtm_dp import mtm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  mtm_cmd_t  cmd,
    output mtm_stat_t stat,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    // Parser state, one slot per port.
    logic [7:0] status_reg [PORT_COUNT];
    logic [6:0] first_reg  [PORT_COUNT];
    phase_t     phase_reg  [PORT_COUNT];

    // Trigger table and its valid bits.
    entry_t           table_mem [TABLE_WORDS];
    logic [TABLE_WORDS-1:0] entry_valid_reg;
    entry_t           rd_data_reg;

    // Message key under search.
    logic [2:0]       key_kind_reg;
    logic [3:0]       key_chan_reg;
    logic [6:0]       key_first_reg;
    logic [6:0]       key_second_reg;
    logic             key_use2_reg;
    logic             key_port_reg;

    // Scan pipeline.
    logic [CNT_W-1:0] rd_cnt_reg;
    logic             cmp_v_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [IDX_W-1:0] hit_idx_reg;

    // Active preset and result register.
    logic [IDX_W-1:0] active_index_reg;
    logic             active_valid_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg;

    logic             port_ok;
    logic             idx_ok;
    logic             is_status;
    logic [3:0]       cls;
    phase_t           cur_phase;
    logic             done_prog;
    logic             done_two;
    logic [2:0]       two_kind;
    logic             msg_done;
    logic             rd_issue;
    logic             entry_match;

    // Decode of the item on the input channel.
    always_comb
    begin
        port_ok   = 32'(in_data.rx_port) < PORT_COUNT;
        idx_ok    = 32'(in_data.entry_index) < TABLE_DEPTH;
        is_status = in_data.midi_byte[7];
        cls       = status_reg[in_data.rx_port][7:4];
        cur_phase = phase_reg[in_data.rx_port];
        done_prog = !is_status && cur_phase == PH_FIRST && cls == CLS_PROG;
        done_two  = !is_status && cur_phase == PH_SECOND;
        case (cls)
            CLS_CTRL:    two_kind = KIND_CTRL;
            CLS_NOTE_ON: two_kind = KIND_NOTE_ON;
            default:     two_kind = KIND_NOTE_OFF;
        endcase
        msg_done  = mode_t'(in_data.mode) == MODE_BYTE && port_ok
                    && (done_prog || done_two);
    end

    // Byte parsers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                status_reg[p] <= '0;
                first_reg[p]  <= '0;
                phase_reg[p]  <= PH_STATUS;
            end
        end
        else if (cmd.take && port_ok && mode_t'(in_data.mode) == MODE_BYTE)
        begin
            if (is_status)
            begin
                status_reg[in_data.rx_port] <= in_data.midi_byte;
                phase_reg[in_data.rx_port]  <= PH_FIRST;
            end
            else if (cur_phase == PH_FIRST)
            begin
                first_reg[in_data.rx_port] <= in_data.midi_byte[6:0];
                if (cls == CLS_PROG || cls == CLS_PRESS)
                begin
                    phase_reg[in_data.rx_port] <= PH_STATUS;
                end
                else
                begin
                    phase_reg[in_data.rx_port] <= PH_SECOND;
                end
            end
            else if (cur_phase == PH_SECOND)
            begin
                phase_reg[in_data.rx_port] <= PH_STATUS;
            end
        end
    end

    // Capture the completed message as the search key.
    always_ff @(posedge clk)
    begin
        if (cmd.take && msg_done)
        begin
            key_chan_reg   <= status_reg[in_data.rx_port][3:0];
            key_port_reg   <= in_data.rx_port;
            if (done_prog)
            begin
                key_kind_reg   <= KIND_PROG;
                key_first_reg  <= in_data.midi_byte[6:0];
                key_second_reg <= '0;
                key_use2_reg   <= 1'b0;
            end
            else
            begin
                key_kind_reg   <= two_kind;
                key_first_reg  <= first_reg[in_data.rx_port];
                key_second_reg <= in_data.midi_byte[6:0];
                key_use2_reg   <= 1'b1;
            end
        end
    end

    // Table memory: one write port for table-write items, one read port for the scan.
    assign rd_issue = cmd.scan && 32'(rd_cnt_reg) < TABLE_DEPTH;

    always_ff @(posedge clk)
    begin
        if (cmd.take && port_ok && idx_ok && mode_t'(in_data.mode) == MODE_WRITE)
        begin
            table_mem[{in_data.rx_port, in_data.entry_index}] <=
                '{kind: in_data.entry_type, chan: in_data.entry_channel,
                  first: in_data.entry_first, second: in_data.entry_second};
        end
        if (rd_issue)
        begin
            rd_data_reg <= table_mem[{key_port_reg, rd_cnt_reg[IDX_W-1:0]}];
        end
    end

    // Valid bits: an entry never written reads as type none.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (cmd.take && port_ok && idx_ok && mode_t'(in_data.mode) == MODE_WRITE)
        begin
            entry_valid_reg[{in_data.rx_port, in_data.entry_index}] <= 1'b1;
        end
    end

    // Scan counters: the read address leads the compare by the registered table read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg  <= '0;
            cmp_v_reg   <= 1'b0;
            cmp_idx_reg <= '0;
        end
        else if (cmd.take)
        begin
            rd_cnt_reg <= '0;
            cmp_v_reg  <= 1'b0;
        end
        else if (cmd.scan)
        begin
            cmp_v_reg   <= rd_issue;
            cmp_idx_reg <= rd_cnt_reg[IDX_W-1:0];
            if (rd_issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end
        end
    end

    // Compare of the entry read in the previous cycle, and the status bundle.
    always_comb
    begin
        entry_match = entry_valid_reg[{key_port_reg, cmp_idx_reg}]
                      && rd_data_reg.kind == key_kind_reg
                      && rd_data_reg.chan == key_chan_reg
                      && rd_data_reg.first == key_first_reg
                      && (!key_use2_reg || rd_data_reg.second == key_second_reg);
        stat.msg_done    = msg_done;
        stat.hit         = cmd.scan && cmp_v_reg && entry_match;
        stat.scan_end    = cmd.scan && cmp_v_reg
                           && 32'(cmp_idx_reg) == TABLE_DEPTH - 1;
        stat.same_active = active_valid_reg && active_index_reg == hit_idx_reg;
        stat.out_busy    = out_valid_reg;
    end

    // Index of the first matching entry.
    always_ff @(posedge clk)
    begin
        if (stat.hit)
        begin
            hit_idx_reg <= cmp_idx_reg;
        end
    end

    // Active preset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_index_reg <= '0;
            active_valid_reg <= 1'b1;
        end
        else if (cmd.emit)
        begin
            active_index_reg <= hit_idx_reg;
            active_valid_reg <= 1'b1;
        end
        else if (cmd.take && port_ok)
        begin
            if (mode_t'(in_data.mode) == MODE_SET && idx_ok)
            begin
                active_index_reg <= in_data.entry_index;
                active_valid_reg <= 1'b1;
            end
            else if (mode_t'(in_data.mode) == MODE_CLEAR)
            begin
                active_valid_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.preset_index <= hit_idx_reg;
            out_data_reg.match_port   <= key_port_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: src/midi_trigger_matcher.sv
// ============================================================================
// MIDI trigger matcher
// Two MIDI byte parsers whose completed messages select presets through
// per-port trigger tables.
// ============================================================================
//
// Channel   Direction  Carries
// request   in         MIDI bytes, table writes, set and clear of the active preset
// result    out        preset newly selected and the port it came from
//
// A byte that completes no message, a table write and a set or clear are taken
// without a scan. A completed message starts a scan of the port's 32 table
// entries, one entry per cycle through the registered table read port. The
// result register holds a finished item while the next request is taken; a
// match stalls only if that register is still full. Reset is asynchronous and
// clears all parser state and the table valid bits and sets the active preset
// to index 0 at once; no clearing pass is needed.
module midi_trigger_matcher import mtm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mtm_in_if.sink    request,
    mtm_out_if.source result
);

    mtm_cmd_t  cmd;
    mtm_stat_t stat;

    // Sequencer.
    mtm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Parsers, table and result register.
    mtm_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (request.data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (result.data)
    );

endmodule
